[hw/rtl/smseq_pkg.sv]
// Package for the stepper move sequencer: command word layout, run modes,
// opcodes, stop codes and timing constants. No dependencies.
package smseq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 8;

    localparam logic [23:0] PERIOD_RESET     = 24'd1000000;
    localparam logic [5:0]  PULSE_TICKS      = 6'd50;
    localparam logic [13:0] SWING_DWELL      = 14'd500;
    localparam logic [13:0] IDLE_DWELL       = 14'd10000;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_DWELL   = 3'd1;
    localparam logic [2:0] OP_MOVE    = 3'd2;
    localparam logic [2:0] OP_HOME    = 3'd3;
    localparam logic [2:0] OP_VIBRATE = 3'd4;

    localparam logic [2:0] STOP_NONE   = 3'd0;
    localparam logic [2:0] STOP_TARGET = 3'd1;
    localparam logic [2:0] STOP_EMER   = 3'd2;
    localparam logic [2:0] STOP_LIMIT  = 3'd3;
    localparam logic [2:0] STOP_HOMED  = 3'd4;

    localparam logic [1:0] PHASE_OUT       = 2'd0;
    localparam logic [1:0] PHASE_OUT_DWELL = 2'd1;
    localparam logic [1:0] PHASE_BACK      = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_DWELL,
        MODE_MOVE,
        MODE_HOME,
        MODE_SWING
    } mode_t;

    // one queued command, op in the low bits
    typedef struct packed {
        logic        front;
        logic [15:0] reps;
        logic [31:0] arg;
        logic [2:0]  op;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

[hw/rtl/smseq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (read-old-data on a same-address write). No dependencies.
module smseq_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/stepper_move_sequencer.sv]
// Stepper move sequencer top level: command queue in smseq_ram, tick engine,
// two-entry output skid. Depends on smseq_pkg and smseq_ram.
//
//  channel  | dir | tdata / tuser                                         | when taken
//  s_       | in  | tuser opcode; tdata target, repeats, limits, estop    | s_tvalid & s_tready
//  m_       | out | tdata pulse, dir, position, busy, drop, stop, queued  | m_tvalid & m_tready
//  cfg_wr_  | in  | step period, 24 bit                                   | cfg_wr_en
//
// One word per cycle while s_tready is high; every word yields one registered result word.
// The queue head is prefetched from RAM, with a bypass for a word
// written the cycle before, so a tick can pop and run a command at once.
// aresetn is synchronous: queue empty, mode idle, period 1000000.
// s_tready drops only while both output slots are full.
module stepper_move_sequencer #(
    parameter int QUEUE_DEPTH = smseq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] target_or_amplitude, [47:32] repeat_count, [48] toward_front,
    // [49] front_limit_hit, [50] rear_limit_hit, [51] emergency_hit
    input  logic [55:0] s_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] step_pulse, [1] direction, [33:2] position, [34] busy_res,
    // [35] command_dropped, [38:36] stop_event, [42:39] queued_commands
    output logic [47:0] m_tdata,

    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // ---------------- registers ----------------
    logic [23:0]          period_reg;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    smseq_pkg::mode_t     mode_reg, mode_next;
    logic signed [31:0]   pos_reg, pos_next;
    logic signed [31:0]   goal_reg, goal_next;
    logic signed [31:0]   amp_reg, amp_next;
    logic [15:0]          cycles_reg, cycles_next;
    logic [1:0]           phase_reg, phase_next;
    logic [23:0]          since_reg, since_next;
    logic                 first_reg, first_next;
    logic [5:0]           pulse_left_reg, pulse_left_next;
    logic [13:0]          dwell_reg, dwell_next;
    logic                 dir_reg, dir_next;
    logic                 byp_valid_reg;
    smseq_pkg::cmd_t      byp_data_reg;

    logic                 out_valid_reg, skid_valid_reg;
    logic [47:0]          out_data_reg, skid_data_reg;

    // ---------------- input decode ----------------
    logic                 s_acc, tick, cmd_in, full, wr_en, pulse_busy, start;
    logic [2:0]           op;
    logic                 front_hit, rear_hit, emer_hit;
    smseq_pkg::cmd_t      wr_cmd, head_cmd;
    logic [smseq_pkg::CMD_W-1:0] rd_word;

    assign s_acc      = s_tvalid && s_tready;
    assign op         = s_tuser;
    assign tick       = s_acc && (op == smseq_pkg::OP_TICK);
    assign cmd_in     = s_acc && (op >= smseq_pkg::OP_DWELL) && (op <= smseq_pkg::OP_VIBRATE);
    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign wr_en      = cmd_in && !full;
    assign pulse_busy = (pulse_left_reg != 6'd0);
    assign start      = tick && !pulse_busy && (mode_reg == smseq_pkg::MODE_IDLE)
                        && (count_reg != '0);
    assign front_hit  = s_tdata[49];
    assign rear_hit   = s_tdata[50];
    assign emer_hit   = s_tdata[51];

    assign wr_cmd.op    = op;
    assign wr_cmd.arg   = s_tdata[31:0];
    assign wr_cmd.reps  = s_tdata[47:32];
    assign wr_cmd.front = s_tdata[48];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign head_next  = start ? ptr_inc(head_reg) : head_reg;
    assign tail_next  = wr_en ? ptr_inc(tail_reg) : tail_reg;
    assign count_next = count_reg + CW'(wr_en) - CW'(start);

    smseq_ram #(
        .WIDTH (smseq_pkg::CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (tail_reg),
        .wdata (wr_cmd),
        .raddr (head_next),
        .rdata (rd_word)
    );

    assign head_cmd = byp_valid_reg ? byp_data_reg : smseq_pkg::cmd_t'(rd_word);

    // ---------------- command start ----------------
    smseq_pkg::mode_t     mode_s;
    logic signed [31:0]   goal_s, amp_s;
    logic [15:0]          cycles_s;
    logic [1:0]           phase_s;
    logic [13:0]          dwell_s;
    logic                 first_s;

    always_comb begin
        mode_s   = mode_reg;
        goal_s   = goal_reg;
        amp_s    = amp_reg;
        cycles_s = cycles_reg;
        phase_s  = phase_reg;
        dwell_s  = dwell_reg;
        first_s  = first_reg;
        if (start) begin
            first_s = 1'b1;
            case (head_cmd.op)
                smseq_pkg::OP_DWELL: begin
                    mode_s  = smseq_pkg::MODE_DWELL;
                    dwell_s = smseq_pkg::IDLE_DWELL;
                end
                smseq_pkg::OP_MOVE: begin
                    mode_s = smseq_pkg::MODE_MOVE;
                    goal_s = head_cmd.arg;
                end
                smseq_pkg::OP_HOME: begin
                    mode_s = smseq_pkg::MODE_HOME;
                    goal_s = {31'd0, head_cmd.front};
                end
                smseq_pkg::OP_VIBRATE: begin
                    if (head_cmd.reps != 16'd0) begin
                        mode_s   = smseq_pkg::MODE_SWING;
                        amp_s    = head_cmd.arg;
                        cycles_s = head_cmd.reps;
                        phase_s  = smseq_pkg::PHASE_OUT;
                        goal_s   = pos_reg + $signed(head_cmd.arg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- tick conditions ----------------
    logic        can_step, goal_eq, goal_gt, home_fwd, home_lim;
    logic [2:0]  move_stop;
    logic [13:0] dwell_dec;
    logic [15:0] cycles_dec;
    logic        work;

    assign work       = tick && !pulse_busy;
    assign can_step   = first_s || (since_reg >= period_reg);
    assign goal_eq    = (goal_s == pos_reg);
    assign goal_gt    = (goal_s > pos_reg);
    assign move_stop  = goal_eq ? smseq_pkg::STOP_TARGET :
                        emer_hit ? smseq_pkg::STOP_EMER :
                        ((goal_gt && front_hit) || (!goal_gt && rear_hit)) ?
                        smseq_pkg::STOP_LIMIT : smseq_pkg::STOP_NONE;
    assign home_fwd   = (goal_s != 32'sd0);
    assign home_lim   = home_fwd ? front_hit : rear_hit;
    assign dwell_dec  = (dwell_s != 14'd0) ? dwell_s - 14'd1 : 14'd0;
    assign cycles_dec = cycles_s - 16'd1;

    // ---------------- run mode ----------------
    always_comb begin
        mode_next = mode_reg;
        if (work) begin
            mode_next = mode_s;
            case (mode_s)
                smseq_pkg::MODE_DWELL: begin
                    if (dwell_dec == 14'd0) begin
                        mode_next = smseq_pkg::MODE_IDLE;
                    end
                end
                smseq_pkg::MODE_MOVE: begin
                    if (move_stop != smseq_pkg::STOP_NONE) begin
                        mode_next = smseq_pkg::MODE_IDLE;
                    end
                end
                smseq_pkg::MODE_HOME: begin
                    if (emer_hit || home_lim) begin
                        mode_next = smseq_pkg::MODE_IDLE;
                    end
                end
                smseq_pkg::MODE_SWING: begin
                    if (phase_s[0] && (dwell_dec == 14'd0) &&
                        (phase_s != smseq_pkg::PHASE_OUT_DWELL) && (cycles_dec == 16'd0)) begin
                        mode_next = smseq_pkg::MODE_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- datapath ----------------
    logic [2:0] stop;
    logic       step_go, step_fwd, pulse_out;

    always_comb begin
        stop            = smseq_pkg::STOP_NONE;
        step_go         = 1'b0;
        step_fwd        = 1'b0;
        pos_next        = pos_reg;
        goal_next       = goal_s;
        amp_next        = amp_s;
        cycles_next     = cycles_s;
        phase_next      = phase_s;
        dwell_next      = dwell_s;
        first_next      = first_s;
        pulse_left_next = pulse_left_reg;
        dir_next        = dir_reg;
        since_next      = since_reg;
        if (tick) begin
            if (pulse_busy) begin
                pulse_left_next = pulse_left_reg - 6'd1;
            end else begin
                case (mode_s)
                    smseq_pkg::MODE_DWELL: begin
                        dwell_next = dwell_dec;
                    end
                    smseq_pkg::MODE_MOVE: begin
                        stop     = move_stop;
                        step_go  = (move_stop == smseq_pkg::STOP_NONE) && can_step;
                        step_fwd = goal_gt;
                    end
                    smseq_pkg::MODE_HOME: begin
                        if (emer_hit) begin
                            stop = smseq_pkg::STOP_EMER;
                        end else if (home_lim) begin
                            stop = smseq_pkg::STOP_HOMED;
                        end else begin
                            step_go  = can_step;
                            step_fwd = home_fwd;
                        end
                        if (stop != smseq_pkg::STOP_NONE) begin
                            pos_next = 32'sd0;
                        end
                    end
                    smseq_pkg::MODE_SWING: begin
                        if (!phase_s[0]) begin
                            stop     = move_stop;
                            step_go  = (move_stop == smseq_pkg::STOP_NONE) && can_step;
                            step_fwd = goal_gt;
                            if (move_stop != smseq_pkg::STOP_NONE) begin
                                phase_next = phase_s + 2'd1;
                                dwell_next = smseq_pkg::SWING_DWELL;
                            end
                        end else begin
                            dwell_next = dwell_dec;
                            if (dwell_dec == 14'd0) begin
                                first_next = 1'b1;
                                if (phase_s == smseq_pkg::PHASE_OUT_DWELL) begin
                                    phase_next = smseq_pkg::PHASE_BACK;
                                    goal_next  = pos_reg - amp_s;
                                end else begin
                                    cycles_next = cycles_dec;
                                    if (cycles_dec != 16'd0) begin
                                        phase_next = smseq_pkg::PHASE_OUT;
                                        goal_next  = pos_reg + amp_s;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (step_go) begin
                    dir_next        = step_fwd;
                    pos_next        = step_fwd ? pos_reg + 32'sd1 : pos_reg - 32'sd1;
                    pulse_left_next = smseq_pkg::PULSE_TICKS - 6'd1;
                    first_next      = 1'b0;
                end
            end
            if (step_go) begin
                since_next = 24'd0;
            end else if (since_reg != '1) begin
                since_next = since_reg + 24'd1;
            end
        end
    end

    assign pulse_out = pulse_busy || step_go;

    logic [47:0] res_word;
    logic        busy_out;

    assign busy_out = (mode_next != smseq_pkg::MODE_IDLE) || (pulse_left_next != 6'd0);
    assign res_word = {5'd0, 4'(count_next), stop, cmd_in && full, busy_out,
                       pos_next, dir_next, pulse_out};

    // ---------------- state update ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= smseq_pkg::PERIOD_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            mode_reg       <= smseq_pkg::MODE_IDLE;
            pos_reg        <= '0;
            goal_reg       <= '0;
            amp_reg        <= '0;
            cycles_reg     <= '0;
            phase_reg      <= '0;
            since_reg      <= '0;
            first_reg      <= 1'b1;
            pulse_left_reg <= '0;
            dwell_reg      <= '0;
            dir_reg        <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (s_acc) begin
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                count_reg      <= count_next;
                mode_reg       <= mode_next;
                pos_reg        <= pos_next;
                goal_reg       <= goal_next;
                amp_reg        <= amp_next;
                cycles_reg     <= cycles_next;
                phase_reg      <= phase_next;
                since_reg      <= since_next;
                first_reg      <= first_next;
                pulse_left_reg <= pulse_left_next;
                dwell_reg      <= dwell_next;
                dir_reg        <= dir_next;
            end
            byp_valid_reg <= wr_en && (tail_reg == head_next);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= wr_cmd;
    end

    // ---------------- output skid ----------------
    logic m_fire;

    assign m_fire   = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_acc) begin
            if (out_valid_reg && !m_fire) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (s_acc) begin
            if (out_valid_reg && !m_fire) begin
                skid_data_reg <= res_word;
            end else begin
                out_data_reg <= res_word;
            end
        end
    end

endmodule

[test/tb_stepper_move_sequencer.sv]
// Self-checking bench for stepper_move_sequencer: a queue/tick motion predictor
// in a scoreboard class, stream drivers with random idling and stalls.
// Depends on smseq_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_stepper_move_sequencer;

    localparam int QDEPTH = smseq_pkg::QUEUE_DEPTH_DEFAULT;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam int PHASE_WORDS = 190;

    typedef struct {
        logic        pulse;
        logic        dir;
        logic [31:0] pos;
        logic        busy;
        logic        dropped;
        logic [2:0]  stop;
        logic [3:0]  queued;
    } report_t;

    class motion_scoreboard;
        logic [23:0]        period;
        smseq_pkg::cmd_t    store [QDEPTH];
        int unsigned        head, tail, count;
        smseq_pkg::mode_t   mode;
        logic [31:0]        pos, goal, amp;
        logic [15:0]        cycles_left;
        logic [1:0]         phase;
        logic [23:0]        since;
        logic               first_pending, started, dir;
        logic [5:0]         pulse_left;
        logic [13:0]        dwell_left;
        report_t            due_reports [$];
        int                 errors;

        function new();
            period = smseq_pkg::PERIOD_RESET;
            head = 0;
            tail = 0;
            count = 0;
            mode = smseq_pkg::MODE_IDLE;
            pos = '0;
            goal = '0;
            amp = '0;
            cycles_left = '0;
            phase = smseq_pkg::PHASE_OUT;
            since = '0;
            first_pending = 1'b1;
            started = 1'b0;
            dir = 1'b0;
            pulse_left = '0;
            dwell_left = '0;
            errors = 0;
        endfunction

        function void try_step(logic fwd);
            if (first_pending || since >= period) begin
                dir = fwd;
                pos = fwd ? pos + 32'd1 : pos - 32'd1;
                pulse_left = smseq_pkg::PULSE_TICKS - 6'd1;
                first_pending = 1'b0;
                started = 1'b1;
            end
        endfunction

        // target wins over emergency, emergency over the limit ahead
        function logic [2:0] run_move(logic fl, logic rl, logic em);
            if (pos == goal) return smseq_pkg::STOP_TARGET;
            if (em) return smseq_pkg::STOP_EMER;
            if (($signed(goal) > $signed(pos) && fl) || ($signed(goal) < $signed(pos) && rl))
                return smseq_pkg::STOP_LIMIT;
            try_step($signed(goal) > $signed(pos));
            return smseq_pkg::STOP_NONE;
        endfunction

        function void note_word(logic [2:0] op, logic [55:0] data);
            report_t         res;
            smseq_pkg::cmd_t c;
            logic [2:0]      stop;
            logic            pulse, fl, rl, em, fwd;
            fl = data[49];
            rl = data[50];
            em = data[51];
            pulse = (pulse_left != 0);
            stop = smseq_pkg::STOP_NONE;
            res.dropped = 1'b0;
            if (op == smseq_pkg::OP_TICK) begin
                started = 1'b0;
                pulse = 1'b0;
                if (pulse_left != 0) begin
                    pulse = 1'b1;
                    pulse_left = pulse_left - 6'd1;
                end else begin
                    if (mode == smseq_pkg::MODE_IDLE && count != 0) begin
                        c = store[head];
                        head = (head + 1) % QDEPTH;
                        count--;
                        first_pending = 1'b1;
                        case (c.op)
                            smseq_pkg::OP_DWELL: begin
                                mode = smseq_pkg::MODE_DWELL;
                                dwell_left = smseq_pkg::IDLE_DWELL;
                            end
                            smseq_pkg::OP_MOVE: begin
                                mode = smseq_pkg::MODE_MOVE;
                                goal = c.arg;
                            end
                            smseq_pkg::OP_HOME: begin
                                mode = smseq_pkg::MODE_HOME;
                                goal = {31'd0, c.front};
                            end
                            smseq_pkg::OP_VIBRATE: begin
                                if (c.reps != 0) begin
                                    mode = smseq_pkg::MODE_SWING;
                                    amp = c.arg;
                                    cycles_left = c.reps;
                                    phase = smseq_pkg::PHASE_OUT;
                                    goal = pos + c.arg;
                                end
                            end
                            default: ;
                        endcase
                    end
                    case (mode)
                        smseq_pkg::MODE_DWELL: begin
                            if (dwell_left != 0) dwell_left = dwell_left - 14'd1;
                            if (dwell_left == 0) mode = smseq_pkg::MODE_IDLE;
                        end
                        smseq_pkg::MODE_MOVE: begin
                            stop = run_move(fl, rl, em);
                            if (stop != smseq_pkg::STOP_NONE) mode = smseq_pkg::MODE_IDLE;
                        end
                        smseq_pkg::MODE_HOME: begin
                            fwd = (goal != 0);
                            if (em) stop = smseq_pkg::STOP_EMER;
                            else if (fwd ? fl : rl) stop = smseq_pkg::STOP_HOMED;
                            else try_step(fwd);
                            if (stop != smseq_pkg::STOP_NONE) begin
                                pos = '0;
                                mode = smseq_pkg::MODE_IDLE;
                            end
                        end
                        smseq_pkg::MODE_SWING: begin
                            if (phase == smseq_pkg::PHASE_OUT || phase == smseq_pkg::PHASE_BACK) begin
                                stop = run_move(fl, rl, em);
                                if (stop != smseq_pkg::STOP_NONE) begin
                                    phase = phase + 2'd1;
                                    dwell_left = smseq_pkg::SWING_DWELL;
                                end
                            end else begin
                                if (dwell_left != 0) dwell_left = dwell_left - 14'd1;
                                if (dwell_left == 0) begin
                                    first_pending = 1'b1;
                                    if (phase == smseq_pkg::PHASE_OUT_DWELL) begin
                                        phase = smseq_pkg::PHASE_BACK;
                                        goal = pos - amp;
                                    end else begin
                                        cycles_left = cycles_left - 16'd1;
                                        if (cycles_left == 0) begin
                                            mode = smseq_pkg::MODE_IDLE;
                                        end else begin
                                            phase = smseq_pkg::PHASE_OUT;
                                            goal = pos + amp;
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (started) pulse = 1'b1;
                end
                if (started) since = '0;
                else if (since != 24'hFFFFFF) since = since + 24'd1;
            end else if (op <= smseq_pkg::OP_VIBRATE) begin
                if (count >= QDEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    c.op = op;
                    c.arg = data[31:0];
                    c.reps = data[47:32];
                    c.front = data[48];
                    store[tail] = c;
                    tail = (tail + 1) % QDEPTH;
                    count++;
                end
            end
            res.pulse = pulse;
            res.dir = dir;
            res.pos = pos;
            res.busy = (mode != smseq_pkg::MODE_IDLE) || (pulse_left != 0);
            res.stop = stop;
            res.queued = count[3:0];
            due_reports.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [47:0] w);
            report_t want;
            if (due_reports.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, w);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("step_pulse", 32'(want.pulse), 32'(w[0]));
            compare_field("direction", 32'(want.dir), 32'(w[1]));
            compare_field("position", want.pos, w[33:2]);
            compare_field("busy_res", 32'(want.busy), 32'(w[34]));
            compare_field("command_dropped", 32'(want.dropped), 32'(w[35]));
            compare_field("stop_event", 32'(want.stop), 32'(w[38:36]));
            compare_field("queued_commands", 32'(want.queued), 32'(w[42:39]));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = smseq_pkg::OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [23:0] cfg_wr_data = '0;

    motion_scoreboard sb = new();
    int send_idle, recv_idle;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int words_sent = 0;
    int swing_ok = 0;
    int lim_pm = 0;
    int emer_pm = 0;

    stepper_move_sequencer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 120;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata);
    end

    function automatic logic [55:0] pack_word(logic [31:0] arg, logic [15:0] reps,
                                              logic front, logic fl, logic rl, logic em);
        return {4'b0, em, rl, fl, front, reps, arg};
    endfunction

    task automatic send_word(logic [2:0] op, logic [55:0] data);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, data);
        words_sent++;
    endtask

    task automatic send_cmd(logic [2:0] op, logic [31:0] arg, logic [15:0] reps, logic front);
        send_word(op, pack_word(arg, reps, front, 1'($urandom), 1'($urandom), 1'($urandom)));
    endtask

    task automatic send_tick(logic fl, logic rl, logic em);
        send_word(smseq_pkg::OP_TICK,
                  pack_word($urandom, 16'($urandom), 1'($urandom), fl, rl, em));
    endtask

    task automatic send_spare(logic [2:0] op);
        send_word(op, pack_word($urandom, 16'($urandom), 1'($urandom),
                                1'($urandom), 1'($urandom), 1'($urandom)));
    endtask

    task automatic random_tick();
        send_tick($urandom_range(999) < lim_pm, $urandom_range(999) < lim_pm,
                  $urandom_range(999) < emer_pm);
    endtask

    task automatic settle(int cap);
        int n;
        n = 0;
        while ((sb.mode != smseq_pkg::MODE_IDLE || sb.count != 0 || sb.pulse_left != 0)
               && n < cap) begin
            random_tick();
            n++;
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.due_reports.size() != 0);
    endtask

    task automatic write_period(logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.period = value;
    endtask

    // mostly short well-formed commands; raw fields only where they cannot stall the run
    task automatic random_command();
        int k, m;
        logic [2:0]  op;
        logic [31:0] arg;
        logic [15:0] reps;
        k = $urandom_range(99);
        if (k < 12) begin
            send_spare(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
            return;
        end
        if (k < 30) begin
            op = 3'($urandom_range(smseq_pkg::OP_DWELL, smseq_pkg::OP_VIBRATE));
            arg = $urandom;
            reps = 16'($urandom);
            if (sb.count < QDEPTH) begin
                if (op == smseq_pkg::OP_VIBRATE) reps = '0;
                if (op == smseq_pkg::OP_DWELL) op = smseq_pkg::OP_MOVE;
            end
        end else begin
            m = $urandom_range(99);
            arg = '0;
            reps = '0;
            if (m < 55) begin
                op = smseq_pkg::OP_MOVE;
                arg = sb.pos + $urandom_range(0, 6) - 3;
            end else if (m < 80) begin
                op = smseq_pkg::OP_HOME;
            end else begin
                op = smseq_pkg::OP_VIBRATE;
                arg = $urandom_range(0, 6) - 3;
                if (swing_ok != 0 && $urandom_range(7) == 0)
                    reps = ($urandom_range(3) == 0) ? 16'd2 : 16'd1;
            end
        end
        send_cmd(op, arg, reps, 1'($urandom));
    endtask

    task automatic run_phase();
        logic pressed;
        int base;
        pressed = 1'b0;
        base = words_sent;
        while (words_sent - base < PHASE_WORDS) begin
            lim_pm = $urandom_range(0, 30);
            emer_pm = $urandom_range(2, 15);
            repeat ($urandom_range(1, 3)) random_command();
            if (!pressed && words_sent - base >= PHASE_WORDS / 2) begin
                pressed = 1'b1;
                hold_req++;
                repeat (8) random_tick();
                wait_drain();
            end
            if ($urandom_range(99) < 15) settle(40);
            else repeat ($urandom_range(1, 12)) random_tick();
        end
    endtask

    initial begin
        send_idle = 35;
        recv_idle = 77;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the queue with every command kind at field extremes, overflow it,
        // then pop them with ticks carrying front limit, rear limit, emergency, all three and none
        send_tick(1'b0, 1'b0, 1'b0);
        send_cmd(smseq_pkg::OP_MOVE, 32'h7FFFFFFF, 16'h0000, 1'b0);
        send_cmd(smseq_pkg::OP_MOVE, 32'h80000000, 16'h0000, 1'b0);
        send_cmd(smseq_pkg::OP_HOME, 32'h00000000, 16'h0000, 1'b1);
        send_cmd(smseq_pkg::OP_HOME, 32'hFFFFFFFF, 16'hFFFF, 1'b0);
        send_cmd(smseq_pkg::OP_VIBRATE, 32'h00000000, 16'h0000, 1'b0);
        send_cmd(smseq_pkg::OP_VIBRATE, 32'h7FFFFFFF, 16'h0000, 1'b0);
        send_cmd(smseq_pkg::OP_VIBRATE, 32'h80000000, 16'h0000, 1'b1);
        send_cmd(smseq_pkg::OP_MOVE, 32'h00000000, 16'h0000, 1'b0);
        send_cmd(smseq_pkg::OP_DWELL, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_spare(3'(op));
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);

        for (int ph = 0; ph < 3; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    write_period(24'hFFFFFF);
                    send_idle = 35;
                    recv_idle = 77;
                    swing_ok = 0;
                end
                1: begin
                    write_period(24'd1);
                    send_idle = 77;
                    recv_idle = 35;
                    swing_ok = 0;
                end
                default: begin
                    write_period(24'($urandom_range(2, 120)));
                    send_idle = 0;
                    recv_idle = 0;
                    swing_ok = 1;
                end
            endcase
            run_phase();
        end

        // idle dwell start and countdown
        send_cmd(smseq_pkg::OP_DWELL, 32'h00000000, 16'h0000, 1'b0);
        repeat (8) random_tick();

        wait_drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.due_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
